@@ rtl/core/altitude_complementary_fusion_assert.svh @@
// Assertion macros for the altitude fusion block.
// Both expect signals named clk and rst in the scope where they are used.
`ifndef ALTITUDE_COMPLEMENTARY_FUSION_ASSERT_SVH
`define ALTITUDE_COMPLEMENTARY_FUSION_ASSERT_SVH
`ifndef SYNTHESIS
`define ACF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ACF_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ACF_ASSERT(lbl, prop, msg)
`define ACF_ASSERT_RST(lbl, prop, msg)
`endif
`endif

@@ rtl/core/acf_pkg.sv @@
package acf_pkg;

  localparam int DATA_WIDTH      = 32;
  localparam int GAIN_WIDTH      = 24;
  localparam int CFG_INDEX_WIDTH = 3;
  localparam int PC_WIDTH        = 5;

  typedef logic signed [DATA_WIDTH-1:0] word_t;
  typedef logic [GAIN_WIDTH-1:0]        gain_t;

  // Last program step: it only hands the result to the output register.
  localparam logic [PC_WIDTH-1:0] STEP_LAST = PC_WIDTH'(26);

  // Fixed blending weights, unsigned Q0.24.
  localparam gain_t W_08 = 24'd13421773;
  localparam gain_t W_02 = 24'd3355443;
  localparam gain_t W_01 = 24'd1677722;
  localparam gain_t W_09 = 24'd15099494;
  localparam gain_t W_03 = 24'd5033165;
  localparam gain_t W_07 = 24'd11744051;
  localparam gain_t W_05 = 24'd8388608;

  localparam gain_t ACC_GAIN_RST     = 24'd10066;
  localparam gain_t VEL_GAIN_RST     = 24'd100663;
  localparam gain_t VEL_ERR_GAIN_RST = 24'd503316;
  localparam gain_t POS_GAIN_RST     = 24'd1006633;
  localparam gain_t STEP_TIME_RST    = 24'd16777;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_ACC_GAIN     = 3'd0,
    REG_VEL_GAIN     = 3'd1,
    REG_VEL_ERR_GAIN = 3'd2,
    REG_POS_GAIN     = 3'd3,
    REG_STEP_TIME    = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    gain_t acc_gain;
    gain_t vel_gain;
    gain_t vel_err_gain;
    gain_t pos_gain;
    gain_t step_time;
  } gains_t;

  // Operand and destination selects of the datapath register set.
  typedef enum logic [4:0] {
    S_ZERO, S_BH, S_BV, S_ACC, S_AUX, S_HD, S_VD, S_T0, S_T1, S_T2, S_T3,
    S_DV, S_AC, S_VCH, S_VCV, S_PC, S_VI, S_HI, S_IH, S_VS, S_PAH, S_PBV,
    S_FA, S_FV, S_FH
  } src_t;

  typedef enum logic [3:0] {
    G_ACC, G_VEL, G_VERR, G_POS, G_STEP,
    G_W08, G_W02, G_W01, G_W09, G_W03, G_W07, G_W05
  } gain_sel_t;

  // ALU_ADDP adds the rounded product of the previous step to operand a.
  typedef enum logic [1:0] {
    ALU_NOP, ALU_ADD, ALU_SUB, ALU_ADDP
  } alu_op_t;

  typedef struct packed {
    logic      mul_en;
    src_t      mul_src;
    gain_sel_t gain;
    alu_op_t   op;
    src_t      a;
    src_t      b;
    src_t      dst;
    logic      last;
  } ctrl_word_t;

  typedef struct packed {
    logic load;
    logic clear;
  } dp_cmd_t;

  localparam ctrl_word_t UC_NOP =
    '{1'b0, S_ZERO, G_ACC, ALU_NOP, S_ZERO, S_ZERO, S_ZERO, 1'b0};

  // Microprogram for one sensor sample. The multiplier result of step n is
  // consumed by the ALU in step n+1; a register written in step n is read
  // from step n+1 on.
  function automatic ctrl_word_t ucode(input logic [PC_WIDTH-1:0] pc);
    ctrl_word_t w;
    w = UC_NOP;
    case (pc)
      5'd0:  w = '{1'b1, S_AUX, G_W08,  ALU_SUB,  S_BH,   S_IH,   S_HD,  1'b0};
      5'd1:  w = '{1'b1, S_PAH, G_W02,  ALU_ADDP, S_ZERO, S_ZERO, S_T0,  1'b0};
      5'd2:  w = '{1'b1, S_HD,  G_ACC,  ALU_ADDP, S_T0,   S_ZERO, S_PAH, 1'b0};
      5'd3:  w = '{1'b1, S_HD,  G_VEL,  ALU_ADDP, S_AC,   S_ZERO, S_AC,  1'b0};
      5'd4:  w = '{1'b1, S_HD,  G_POS,  ALU_ADDP, S_VCH,  S_ZERO, S_VCH, 1'b0};
      5'd5:  w = '{1'b1, S_BV,  G_W01,  ALU_ADDP, S_PC,   S_ZERO, S_PC,  1'b0};
      5'd6:  w = '{1'b1, S_PBV, G_W09,  ALU_ADDP, S_ZERO, S_ZERO, S_T1,  1'b0};
      5'd7:  w = '{1'b0, S_ZERO, G_ACC, ALU_ADDP, S_T1,   S_ZERO, S_PBV, 1'b0};
      5'd8:  w = '{1'b0, S_ZERO, G_ACC, ALU_SUB,  S_BV,   S_VS,   S_VD,  1'b0};
      5'd9:  w = '{1'b1, S_VD,  G_VERR, ALU_ADD,  S_ACC,  S_AC,   S_FA,  1'b0};
      5'd10: w = '{1'b1, S_FA,  G_STEP, ALU_ADDP, S_VCV,  S_ZERO, S_VCV, 1'b0};
      5'd11: w = '{1'b0, S_ZERO, G_ACC, ALU_ADDP, S_ZERO, S_ZERO, S_DV,  1'b0};
      5'd12: w = '{1'b0, S_ZERO, G_ACC, ALU_ADD,  S_VI,   S_DV,   S_VI,  1'b0};
      5'd13: w = '{1'b0, S_ZERO, G_ACC, ALU_ADD,  S_VI,   S_VCH,  S_T0,  1'b0};
      5'd14: w = '{1'b0, S_ZERO, G_ACC, ALU_ADD,  S_T0,   S_VCV,  S_T0,  1'b0};
      5'd15: w = '{1'b1, S_T0,  G_W01,  ALU_NOP,  S_ZERO, S_ZERO, S_ZERO, 1'b0};
      5'd16: w = '{1'b1, S_VS,  G_W09,  ALU_ADDP, S_ZERO, S_ZERO, S_T1,  1'b0};
      5'd17: w = '{1'b1, S_DV,  G_W05,  ALU_ADDP, S_T1,   S_ZERO, S_VS,  1'b0};
      5'd18: w = '{1'b1, S_VS,  G_W08,  ALU_ADDP, S_VS,   S_ZERO, S_T2,  1'b0};
      5'd19: w = '{1'b1, S_PBV, G_W02,  ALU_ADDP, S_ZERO, S_ZERO, S_T3,  1'b0};
      5'd20: w = '{1'b1, S_T2,  G_STEP, ALU_ADDP, S_T3,   S_ZERO, S_FV,  1'b0};
      5'd21: w = '{1'b0, S_ZERO, G_ACC, ALU_ADDP, S_HI,   S_ZERO, S_HI,  1'b0};
      5'd22: w = '{1'b0, S_ZERO, G_ACC, ALU_ADD,  S_HI,   S_PC,   S_IH,  1'b0};
      5'd23: w = '{1'b1, S_IH,  G_W03,  ALU_NOP,  S_ZERO, S_ZERO, S_ZERO, 1'b0};
      5'd24: w = '{1'b1, S_PAH, G_W07,  ALU_ADDP, S_ZERO, S_ZERO, S_T0,  1'b0};
      5'd25: w = '{1'b0, S_ZERO, G_ACC, ALU_ADDP, S_T0,   S_ZERO, S_FH,  1'b0};
      default: begin
        w = UC_NOP;
        w.last = 1'b1;
      end
    endcase
    return w;
  endfunction

endpackage

@@ rtl/core/acf_datapath.sv @@
module acf_datapath import acf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  ctrl_word_t ctrl,
  input  dp_cmd_t    cmd,
  input  gains_t     gains,
  input  word_t      baro_height,
  input  word_t      baro_velocity,
  input  word_t      vertical_accel,
  input  word_t      aux_height,
  output word_t      fa,
  output word_t      fv,
  output word_t      fh
);

  localparam int PROD_WIDTH = DATA_WIDTH + GAIN_WIDTH + 1;
  localparam logic signed [PROD_WIDTH-1:0] PROD_HALF =
    PROD_WIDTH'(1) << (GAIN_WIDTH - 1);

  typedef struct packed {
    word_t bh;
    word_t bv;
    word_t acc;
    word_t aux;
    word_t hd;
    word_t vd;
    word_t t0;
    word_t t1;
    word_t t2;
    word_t t3;
    word_t dv;
    word_t accel_corr;
    word_t vel_corr_height;
    word_t vel_corr_vel;
    word_t pos_corr;
    word_t vel_integral;
    word_t height_integral;
    word_t inertial_height;
    word_t smoothed_velocity;
    word_t prev_aux_height;
    word_t prev_baro_velocity;
    word_t fa;
    word_t fv;
    word_t fh;
  } regs_t;

  regs_t regs;
  regs_t regs_next;

  logic signed [PROD_WIDTH-1:0] prod;
  logic signed [PROD_WIDTH-1:0] prod_rnd;
  logic signed [PROD_WIDTH-1:0] prod_shift;
  word_t                        mq;
  word_t                        mul_a;
  gain_t                        mul_g;
  word_t                        alu_a;
  word_t                        alu_b;
  logic signed [DATA_WIDTH:0]   sum;
  word_t                        alu_y;

  function automatic word_t pick(input regs_t r, input src_t s);
    word_t v;
    v = '0;
    case (s)
      S_ZERO: v = '0;
      S_BH:   v = r.bh;
      S_BV:   v = r.bv;
      S_ACC:  v = r.acc;
      S_AUX:  v = r.aux;
      S_HD:   v = r.hd;
      S_VD:   v = r.vd;
      S_T0:   v = r.t0;
      S_T1:   v = r.t1;
      S_T2:   v = r.t2;
      S_T3:   v = r.t3;
      S_DV:   v = r.dv;
      S_AC:   v = r.accel_corr;
      S_VCH:  v = r.vel_corr_height;
      S_VCV:  v = r.vel_corr_vel;
      S_PC:   v = r.pos_corr;
      S_VI:   v = r.vel_integral;
      S_HI:   v = r.height_integral;
      S_IH:   v = r.inertial_height;
      S_VS:   v = r.smoothed_velocity;
      S_PAH:  v = r.prev_aux_height;
      S_PBV:  v = r.prev_baro_velocity;
      S_FA:   v = r.fa;
      S_FV:   v = r.fv;
      S_FH:   v = r.fh;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic gain_t pick_gain(input gains_t g, input gain_sel_t s);
    gain_t v;
    v = '0;
    case (s)
      G_ACC:  v = g.acc_gain;
      G_VEL:  v = g.vel_gain;
      G_VERR: v = g.vel_err_gain;
      G_POS:  v = g.pos_gain;
      G_STEP: v = g.step_time;
      G_W08:  v = W_08;
      G_W02:  v = W_02;
      G_W01:  v = W_01;
      G_W09:  v = W_09;
      G_W03:  v = W_03;
      G_W07:  v = W_07;
      G_W05:  v = W_05;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic word_t sat(input logic signed [DATA_WIDTH:0] v);
    word_t r;
    if (v[DATA_WIDTH] != v[DATA_WIDTH-1]) begin
      r = v[DATA_WIDTH] ? {1'b1, {(DATA_WIDTH-1){1'b0}}} : {1'b0, {(DATA_WIDTH-1){1'b1}}};
    end else begin
      r = v[DATA_WIDTH-1:0];
    end
    return r;
  endfunction

  // Product rounded half up to Q16.16: floor((v * g + 2^23) / 2^24).
  always_comb begin
    prod_rnd   = prod + PROD_HALF;
    prod_shift = prod_rnd >>> GAIN_WIDTH;
    mq         = sat(prod_shift[DATA_WIDTH:0]);
  end

  always_comb begin
    mul_a = pick(regs, ctrl.mul_src);
    mul_g = pick_gain(gains, ctrl.gain);
    alu_a = pick(regs, ctrl.a);
    alu_b = (ctrl.op == ALU_ADDP) ? mq : pick(regs, ctrl.b);
    if (ctrl.op == ALU_SUB) begin
      sum = {alu_a[DATA_WIDTH-1], alu_a} - {alu_b[DATA_WIDTH-1], alu_b};
    end else begin
      sum = {alu_a[DATA_WIDTH-1], alu_a} + {alu_b[DATA_WIDTH-1], alu_b};
    end
    alu_y = sat(sum);
  end

  always_comb begin
    regs_next = regs;
    if (cmd.load) begin
      regs_next.bh  = baro_height;
      regs_next.bv  = baro_velocity;
      regs_next.acc = vertical_accel;
      regs_next.aux = aux_height;
    end
    if (cmd.clear) begin
      regs_next.vel_integral    = '0;
      regs_next.height_integral = '0;
    end
    if (ctrl.op != ALU_NOP) begin
      case (ctrl.dst)
        S_HD:    regs_next.hd                 = alu_y;
        S_VD:    regs_next.vd                 = alu_y;
        S_T0:    regs_next.t0                 = alu_y;
        S_T1:    regs_next.t1                 = alu_y;
        S_T2:    regs_next.t2                 = alu_y;
        S_T3:    regs_next.t3                 = alu_y;
        S_DV:    regs_next.dv                 = alu_y;
        S_AC:    regs_next.accel_corr         = alu_y;
        S_VCH:   regs_next.vel_corr_height    = alu_y;
        S_VCV:   regs_next.vel_corr_vel       = alu_y;
        S_PC:    regs_next.pos_corr           = alu_y;
        S_VI:    regs_next.vel_integral       = alu_y;
        S_HI:    regs_next.height_integral    = alu_y;
        S_IH:    regs_next.inertial_height    = alu_y;
        S_VS:    regs_next.smoothed_velocity  = alu_y;
        S_PAH:   regs_next.prev_aux_height    = alu_y;
        S_PBV:   regs_next.prev_baro_velocity = alu_y;
        S_FA:    regs_next.fa                 = alu_y;
        S_FV:    regs_next.fv                 = alu_y;
        S_FH:    regs_next.fh                 = alu_y;
        default: regs_next = regs_next;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
    end else begin
      regs <= regs_next;
    end
  end

  // The product register holds its value on steps without a multiply.
  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod <= PROD_WIDTH'(mul_a) * PROD_WIDTH'($signed({1'b0, mul_g}));
    end
  end

  assign fa = regs.fa;
  assign fv = regs.fv;
  assign fh = regs.fh;

endmodule

@@ rtl/core/altitude_complementary_fusion.sv @@
// Channel  Handshake                     Payload
// sample   sample_valid / sample_ready   kind, baro_height, baro_velocity,
//                                        vertical_accel, aux_height
// result   result_valid / result_ready   fused_accel, fused_velocity, fused_height
// config   cfg_valid / cfg_ready         cfg_index, cfg_data
//
// A sensor sample runs a 26-step microprogram on one shared 32x25 multiplier and one
// saturating adder, then one step loads the result register. A reset item clears the
// integrators on transfer and goes straight to the step that loads the result register.
// The next sample is taken once the program ends, even while the result waits, and the
// final step holds while the result register is still occupied. Reset restores the
// register defaults and clears all filter state.
module altitude_complementary_fusion import acf_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       sample_valid,
  output logic                       sample_ready,
  input  logic                       kind,
  input  word_t                      baro_height,
  input  word_t                      baro_velocity,
  input  word_t                      vertical_accel,
  input  word_t                      aux_height,
  output logic                       result_valid,
  input  logic                       result_ready,
  output word_t                      fused_accel,
  output word_t                      fused_velocity,
  output word_t                      fused_height,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  gain_t                      cfg_data
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t               state;
  logic [PC_WIDTH-1:0]  pc;
  logic                 zero_out;
  gains_t               gains;
  ctrl_word_t           ctrl;
  dp_cmd_t              cmd;
  logic                 accept;
  logic                 commit;
  word_t                fa;
  word_t                fv;
  word_t                fh;

  assign cfg_ready    = 1'b1;
  assign sample_ready = (state == ST_IDLE);
  assign accept       = sample_valid && sample_ready;
  assign ctrl         = (state == ST_RUN) ? ucode(pc) : UC_NOP;
  assign commit       = (state == ST_RUN) && ctrl.last && (!result_valid || result_ready);
  assign cmd.load     = accept && !kind;
  assign cmd.clear    = accept && kind;

  always_ff @(posedge clk) begin
    if (rst) begin
      gains.acc_gain     <= ACC_GAIN_RST;
      gains.vel_gain     <= VEL_GAIN_RST;
      gains.vel_err_gain <= VEL_ERR_GAIN_RST;
      gains.pos_gain     <= POS_GAIN_RST;
      gains.step_time    <= STEP_TIME_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ACC_GAIN:     gains.acc_gain     <= cfg_data;
        REG_VEL_GAIN:     gains.vel_gain     <= cfg_data;
        REG_VEL_ERR_GAIN: gains.vel_err_gain <= cfg_data;
        REG_POS_GAIN:     gains.pos_gain     <= cfg_data;
        REG_STEP_TIME:    gains.step_time    <= cfg_data;
        default:          gains              <= gains;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      pc       <= '0;
      zero_out <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state    <= ST_RUN;
            zero_out <= kind;
            // A reset item goes straight to the step that loads the result.
            pc       <= kind ? STEP_LAST : '0;
          end
        end
        ST_RUN: begin
          if (commit) begin
            state <= ST_IDLE;
          end else if (!ctrl.last) begin
            pc <= pc + 1'b1;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (commit) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      fused_accel    <= zero_out ? '0 : fa;
      fused_velocity <= zero_out ? '0 : fv;
      fused_height   <= zero_out ? '0 : fh;
    end
  end

  acf_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .ctrl           (ctrl),
    .cmd            (cmd),
    .gains          (gains),
    .baro_height    (baro_height),
    .baro_velocity  (baro_velocity),
    .vertical_accel (vertical_accel),
    .aux_height     (aux_height),
    .fa             (fa),
    .fv             (fv),
    .fh             (fh)
  );

`include "altitude_complementary_fusion_assert.svh"

  `ACF_ASSERT(a_pc_in_program, pc <= STEP_LAST, "step counter ran past the program")
  `ACF_ASSERT(a_reset_item_path, (accept && kind) |=> (zero_out && pc == STEP_LAST), "reset item did not go to the final step")
  `ACF_ASSERT(a_result_from_run, $rose(result_valid) |-> $past(state == ST_RUN), "result appeared outside a program run")
  `ACF_ASSERT_RST(a_reset_idle, rst |=> (state == ST_IDLE && !result_valid), "reset left the sequencer busy")

endmodule
